// File: sv/uirb_pkg.sv
// ----------------------------------------------------------------------------
// uirb_pkg
// Shared types, codes and sizes for the UART receiver with idle-timed buffer.
// ----------------------------------------------------------------------------
package uirb_pkg;

	localparam int BUF_DEPTH = 32;
	localparam int BUF_AW    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
	localparam int IDX_W     = 5;
	localparam int WP_XW     = (BUF_AW > IDX_W) ? BUF_AW : IDX_W;
	localparam int CNT_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int OQ_DEPTH  = 3;

	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_FLUSH = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_HALF_BIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BIT      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE     = 2'd2;

	localparam logic [CNT_W-1:0] HALF_BIT_RST = 16'd590;
	localparam logic [CNT_W-1:0] BIT_RST      = 16'd1180;
	localparam logic [CNT_W-1:0] IDLE_RST     = 16'd12536;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_START,
		PH_DATA,
		PH_STOP
	} rx_phase_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic             rx_level;
		logic [IDX_W-1:0] read_index;
	} in_item_t;

	typedef struct packed {
		logic             byte_done;
		logic [7:0]       byte_value;
		logic             frame_error;
		logic             busy_res;
		logic [IDX_W-1:0] bytes_held;
		logic             data_ready;
		logic [7:0]       read_data;
	} out_item_t;

	typedef struct packed {
		logic              en;
		logic [BUF_AW-1:0] addr;
		logic [7:0]        data;
	} wr_req_t;

	typedef struct packed {
		logic             byte_done;
		logic             frame_error;
		logic             busy;
		logic [7:0]       last_byte;
		logic [IDX_W-1:0] bytes_held;
		logic             data_ready;
	} rx_stat_t;

endpackage

// File: sv/uart_receiver_idle_buffer_core.sv
// A result beat is registered behind its accepted item, then written into the output queue
// and shown on out_data while out_valid is high; it is taken when out_stall is low.
// Throughput: one item per cycle when not stalled; at most one RAM read or write a cycle.
// Input stalls only when three results are queued or in flight behind a stalled output.
// Reset clears the receiver, timers, write pointer and every buffer valid flag at once;
// no clearing pass, items are accepted from the first cycle after reset.
// ----------------------------------------------------------------------------
// uart_receiver_idle_buffer_core
// 8N1 UART receiver with a wrapping receive buffer and idle timeout.
// ----------------------------------------------------------------------------
module uart_receiver_idle_buffer_core import uirb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_data,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CNT_W-1:0]     cfg_data
);

	logic      accept;
	logic      vld_s1, rd_s1;
	wr_req_t   wr_req;
	rx_stat_t  stat;
	logic [7:0] rd_data;
	out_item_t res_s1;
	logic [1:0] q_count;
	logic [2:0] occupancy;

	assign occupancy = 3'(q_count) + 3'(vld_s1);
	assign in_stall  = (occupancy >= 3'(OQ_DEPTH));
	assign accept    = in_valid && !in_stall;

	uirb_rx_core u_rx (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.kind      (in_data.kind),
		.rx_level  (in_data.rx_level),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.wr_req    (wr_req),
		.stat      (stat)
	);

	uirb_buffer u_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_req   (wr_req),
		.flush    (accept && (in_data.kind == KIND_FLUSH)),
		.rd_en    (accept && (in_data.kind == KIND_READ)),
		.rd_index (in_data.read_index),
		.rd_data  (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			rd_s1  <= 1'b0;
		end else begin
			vld_s1 <= accept;
			rd_s1  <= accept && (in_data.kind == KIND_READ);
		end
	end

	always_comb begin
		res_s1.byte_done   = stat.byte_done;
		res_s1.byte_value  = stat.last_byte;
		res_s1.frame_error = stat.frame_error;
		res_s1.busy_res    = stat.busy;
		res_s1.bytes_held  = stat.bytes_held;
		res_s1.data_ready  = stat.data_ready;
		res_s1.read_data   = rd_s1 ? rd_data : 8'd0;
	end

	uirb_out_queue u_oq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (vld_s1),
		.push_item (res_s1),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.count     (q_count)
	);

endmodule

// File: sv/uirb_rx_core.sv
// ----------------------------------------------------------------------------
// uirb_rx_core
// Frame receiver, bit timing, idle timer, write pointer and config registers.
// ----------------------------------------------------------------------------
module uirb_rx_core import uirb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [1:0]           kind,
	input  logic                 rx_level,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CNT_W-1:0]     cfg_data,
	output wr_req_t              wr_req,
	output rx_stat_t             stat
);

	logic [CNT_W-1:0]  half_q, bit_q, idle_q;
	rx_phase_t         phase_q, phase_d;
	logic [CNT_W-1:0]  tick_q, tick_d;
	logic [3:0]        bitcnt_q, bitcnt_d;
	logic [7:0]        shift_q, shift_d;
	logic              start_q, start_d;
	logic [7:0]        last_q, last_d;
	logic [BUF_AW-1:0] wp_q, wp_d;
	logic              busy_q, busy_d;
	logic [CNT_W-1:0]  idle_cnt_q, idle_cnt_d;
	logic              idle_run_q, idle_run_d;
	logic              done_q, done_d;
	logic              ferr_q, ferr_d;
	logic              tick, flush, due;
	logic [WP_XW-1:0]  wp_x;

	assign tick  = accept && (kind == KIND_TICK);
	assign flush = accept && (kind == KIND_FLUSH);
	assign due   = (tick_q <= CNT_W'(1));

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= HALF_BIT_RST;
			bit_q  <= BIT_RST;
			idle_q <= IDLE_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_HALF_BIT: half_q <= cfg_data;
				REG_BIT:      bit_q  <= cfg_data;
				REG_IDLE:     idle_q <= cfg_data;
				default:      ;
			endcase
		end
	end

	// phase register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_comb begin
		phase_d    = phase_q;
		tick_d     = tick_q;
		bitcnt_d   = bitcnt_q;
		shift_d    = shift_q;
		start_d    = start_q;
		last_d     = last_q;
		wp_d       = wp_q;
		busy_d     = busy_q;
		idle_cnt_d = idle_cnt_q;
		idle_run_d = idle_run_q;
		done_d     = 1'b0;
		ferr_d     = 1'b0;
		wr_req     = '0;
		if (tick) begin
			if (idle_run_q) begin
				if (idle_cnt_q > CNT_W'(1)) begin
					idle_cnt_d = idle_cnt_q - CNT_W'(1);
				end else begin
					idle_cnt_d = '0;
					idle_run_d = 1'b0;
					busy_d     = 1'b0;
				end
			end
			unique case (phase_q)
				PH_IDLE: begin
					if (!rx_level) begin
						busy_d     = 1'b1;
						idle_run_d = 1'b0;
						idle_cnt_d = '0;
						tick_d     = half_q;
						phase_d    = PH_START;
					end
				end
				PH_START: begin
					if (!due) begin
						tick_d = tick_q - CNT_W'(1);
					end else begin
						tick_d   = bit_q;
						start_d  = rx_level;
						shift_d  = '0;
						bitcnt_d = '0;
						phase_d  = PH_DATA;
					end
				end
				PH_DATA: begin
					if (!due) begin
						tick_d = tick_q - CNT_W'(1);
					end else begin
						tick_d   = bit_q;
						shift_d  = {rx_level, shift_q[7:1]};
						bitcnt_d = bitcnt_q + 4'd1;
						if (bitcnt_d >= 4'd8) begin
							phase_d = PH_STOP;
						end
					end
				end
				PH_STOP: begin
					if (!due) begin
						tick_d = tick_q - CNT_W'(1);
					end else begin
						if (!start_q && rx_level) begin
							wr_req.en   = 1'b1;
							wr_req.addr = wp_q;
							wr_req.data = shift_q;
							wp_d        = (wp_q == BUF_AW'(BUF_DEPTH - 1)) ? '0
							              : wp_q + BUF_AW'(1);
							last_d      = shift_q;
							done_d      = 1'b1;
							idle_cnt_d  = idle_q;
							idle_run_d  = 1'b1;
						end else begin
							ferr_d = 1'b1;
						end
						tick_d   = '0;
						bitcnt_d = '0;
						phase_d  = PH_IDLE;
					end
				end
				default: ;
			endcase
		end else if (flush) begin
			wp_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q     <= '0;
			bitcnt_q   <= '0;
			shift_q    <= '0;
			start_q    <= 1'b1;
			last_q     <= '0;
			wp_q       <= '0;
			busy_q     <= 1'b1;
			idle_cnt_q <= '0;
			idle_run_q <= 1'b0;
			done_q     <= 1'b0;
			ferr_q     <= 1'b0;
		end else begin
			tick_q     <= tick_d;
			bitcnt_q   <= bitcnt_d;
			shift_q    <= shift_d;
			start_q    <= start_d;
			last_q     <= last_d;
			wp_q       <= wp_d;
			busy_q     <= busy_d;
			idle_cnt_q <= idle_cnt_d;
			idle_run_q <= idle_run_d;
			if (accept) begin
				done_q <= done_d;
				ferr_q <= ferr_d;
			end
		end
	end

	assign wp_x = WP_XW'(wp_q);

	assign stat.byte_done   = done_q;
	assign stat.frame_error = ferr_q;
	assign stat.busy        = busy_q;
	assign stat.last_byte   = last_q;
	assign stat.bytes_held  = wp_x[IDX_W-1:0];
	assign stat.data_ready  = !busy_q && (wp_q != '0);

	a_wp_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(wp_q) < BUF_DEPTH)
		else $error("write pointer past buffer depth");

	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		(tick && phase_q == PH_IDLE && !rx_level) |=> (busy_q && phase_q == PH_START))
		else $error("low line while idle did not start a frame");

	a_good_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(tick && phase_q == PH_STOP && due && !start_q && rx_level)
		|=> (done_q && !ferr_q && phase_q == PH_IDLE && last_q == $past(shift_q)))
		else $error("good frame not stored");

endmodule

// File: sv/uirb_buffer.sv
// ----------------------------------------------------------------------------
// uirb_buffer
// Receive buffer RAM with per-entry valid flags; flush clears all flags.
// ----------------------------------------------------------------------------
module uirb_buffer import uirb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  wr_req_t          wr_req,
	input  logic             flush,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_index,
	output logic [7:0]       rd_data
);

	localparam int RW = WP_XW + 1;

	logic [7:0]           mem_q [BUF_DEPTH];
	logic [BUF_DEPTH-1:0] valid_q;
	logic [7:0]           data_s1;
	logic                 hit_s1;
	logic [RW-1:0]        idx_x;
	logic                 in_range;
	logic [BUF_AW-1:0]    rd_addr;

	assign idx_x    = RW'(rd_index);
	assign in_range = idx_x < RW'(BUF_DEPTH);
	assign rd_addr  = idx_x[BUF_AW-1:0];

	always_ff @(posedge clk) begin
		if (wr_req.en) begin
			mem_q[wr_req.addr] <= wr_req.data;
		end
		if (rd_en) begin
			data_s1 <= mem_q[rd_addr];
		end
	end

	// unwritten or flushed entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			hit_s1  <= 1'b0;
		end else begin
			if (flush) begin
				valid_q <= '0;
			end else if (wr_req.en) begin
				valid_q[wr_req.addr] <= 1'b1;
			end
			if (rd_en) begin
				hit_s1 <= in_range && valid_q[rd_addr];
			end
		end
	end

	assign rd_data = hit_s1 ? data_s1 : 8'd0;

endmodule

// File: sv/uirb_out_queue.sv
// ----------------------------------------------------------------------------
// uirb_out_queue
// Small result queue that decouples the output stall from the input side.
// ----------------------------------------------------------------------------
module uirb_out_queue import uirb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  out_item_t push_item,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data,
	output logic [1:0] count
);

	out_item_t  q_q [OQ_DEPTH];
	logic [1:0] head_q, tail_q, count_q;
	logic       pop;

	assign out_valid = (count_q != 2'd0);
	assign pop       = out_valid && !out_stall;
	assign out_data  = q_q[head_q];
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[tail_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				tail_q <= (tail_q == 2'(OQ_DEPTH - 1)) ? 2'd0 : tail_q + 2'd1;
			end
			if (pop) begin
				head_q <= (head_q == 2'(OQ_DEPTH - 1)) ? 2'd0 : head_q + 2'd1;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule
